// File: sv/integer_to_ascii_formatter_defines.svh
// ----------------------------------------------------------------------------
// Integer to ASCII formatter: assertion macros
// Shared concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH

`ifndef SYNTHESIS

// expr must hold at every clock edge out of reset
`define I2A_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("i2a: assertion failed");

// cons must hold in the cycle after ante
`define I2A_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2a: assertion failed");

`else

`define I2A_ASSERT(lbl, expr)
`define I2A_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: sv/i2a_pkg.sv
// ----------------------------------------------------------------------------
// i2a_pkg
// Shared types, constants and the digit-to-ASCII mapping.
// ----------------------------------------------------------------------------
package i2a_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int OPCODE_W        = 3;
  localparam int VALUE_FIELD_W   = 32;
  localparam int CHAR_W          = 8;

  // input opcodes
  localparam logic [OPCODE_W-1:0] OP_SDEC = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_UDEC = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_OCT  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_HEXL = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_HEXU = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_LIT  = 3'd5;

  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;

  // conversion kind after decode
  typedef enum logic [2:0] {
    KIND_DEC,
    KIND_OCT,
    KIND_HEXL,
    KIND_HEXU,
    KIND_LIT
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic  neg;
  } ctl_t;

  localparam int CTL_W = $bits(ctl_t);

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + CHAR_W'(d);
    end else if (upper) begin
      c = CH_UPPER_A + CHAR_W'(d - 4'd10);
    end else begin
      c = CH_LOWER_A + CHAR_W'(d - 4'd10);
    end
    return c;
  endfunction

endpackage

// File: sv/i2a_front.sv
// ----------------------------------------------------------------------------
// i2a_front
// Decodes the opcode, masks the operand and takes the magnitude of negative
// signed values; pushes one entry per accepted word with a used opcode.
// ----------------------------------------------------------------------------
module i2a_front #(
  parameter int VALUE_WIDTH = i2a_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [i2a_pkg::OPCODE_W-1:0]        in_opcode,
  input  logic [i2a_pkg::VALUE_FIELD_W-1:0]   in_value,
  input  logic                                q_full,
  output logic                                push,
  output i2a_pkg::ctl_t                       push_ctl,
  output logic [VALUE_WIDTH-1:0]              push_mag
);

  logic [VALUE_WIDTH-1:0] x;
  logic                   op_ok;

  // truncates below 32 bits, zero-extends above
  assign x = VALUE_WIDTH'(in_value);

  always_comb begin
    push_ctl.kind = i2a_pkg::KIND_DEC;
    push_ctl.neg  = 1'b0;
    push_mag      = x;
    op_ok         = 1'b1;
    unique case (in_opcode)
      i2a_pkg::OP_SDEC: begin
        if (x[VALUE_WIDTH-1]) begin
          push_ctl.neg = 1'b1;
          push_mag     = ~x + VALUE_WIDTH'(1);
        end
      end
      i2a_pkg::OP_UDEC: push_ctl.kind = i2a_pkg::KIND_DEC;
      i2a_pkg::OP_OCT:  push_ctl.kind = i2a_pkg::KIND_OCT;
      i2a_pkg::OP_HEXL: push_ctl.kind = i2a_pkg::KIND_HEXL;
      i2a_pkg::OP_HEXU: push_ctl.kind = i2a_pkg::KIND_HEXU;
      i2a_pkg::OP_LIT:  push_ctl.kind = i2a_pkg::KIND_LIT;
      default: op_ok = 1'b0;
    endcase
  end

  // unused opcodes are taken and dropped
  assign in_stall = q_full;
  assign push     = in_valid && !q_full && op_ok;

endmodule

// File: sv/i2a_queue.sv
// ----------------------------------------------------------------------------
// i2a_queue
// Two-entry FIFO between the decode front and the conversion back end.
// ----------------------------------------------------------------------------
`include "integer_to_ascii_formatter_defines.svh"

module i2a_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output logic              not_empty,
  output logic              full
);

  logic [DATA_W-1:0] mem_r [2];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        count_r, count_nxt;

  assign not_empty = (count_r != 2'd0);
  assign full      = (count_r == 2'd2);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `I2A_ASSERT(a_q_no_overflow, !(push && full))
  `I2A_ASSERT(a_q_no_underflow, !(pop && !not_empty))
  `I2A_ASSERT(a_q_count_range, count_r != 2'd3)

endmodule

// File: sv/i2a_back.sv
// ----------------------------------------------------------------------------
// i2a_back
// Converts one queued entry at a time into a digit register (double dabble
// for decimal, bit-group split for octal and hex), then emits characters
// most significant first through a registered output word; literals skip conversion.
// ----------------------------------------------------------------------------
`include "integer_to_ascii_formatter_defines.svh"

module i2a_back #(
  parameter int VALUE_WIDTH = i2a_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  i2a_pkg::ctl_t                 q_ctl,
  input  logic [VALUE_WIDTH-1:0]        q_mag,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [i2a_pkg::CHAR_W-1:0]    out_character,
  output logic                          out_last
);

  localparam int NDIG        = (VALUE_WIDTH + 2) / 3;
  localparam int DIG_W       = 4 * NDIG;
  localparam int OCT_W       = 3 * NDIG;
  localparam int MW          = ((VALUE_WIDTH + 3) / 4) * 4;
  localparam int DD_STEPS    = 4;
  localparam int CONV_CYCLES = MW / DD_STEPS;
  localparam int CNT_W       = $clog2(CONV_CYCLES + 1);
  localparam int PTR_W       = $clog2(NDIG);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_SCAN,
    S_EMIT
  } state_t;

  state_t                      state_r, state_nxt;
  i2a_pkg::kind_t              kind_r, kind_nxt;
  logic                        neg_r, neg_nxt;
  logic [MW-1:0]               mag_r, mag_nxt;
  logic [DIG_W-1:0]            digits_r, digits_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [PTR_W-1:0]            ptr_r, ptr_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [i2a_pkg::CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic                        out_last_r, out_last_nxt;

  logic [MW-1:0]    mag_pad;
  logic [OCT_W-1:0] mag_oct;
  logic [DIG_W-1:0] oct_digits;
  logic [DIG_W-1:0] dd_digits;
  logic [MW-1:0]    dd_mag;
  logic [PTR_W-1:0] lead;
  logic [3:0]       cur_digit;
  logic             out_load;

  assign mag_pad = MW'(q_mag);
  assign mag_oct = OCT_W'(q_mag);

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      oct_digits[4*i +: 4] = {1'b0, mag_oct[3*i +: 3]};
    end
  end

  // double dabble, DD_STEPS input bits per cycle
  always_comb begin
    logic [DIG_W-1:0] bcd;
    logic [MW-1:0]    m;
    bcd = digits_r;
    m   = mag_r;
    for (int s = 0; s < DD_STEPS; s++) begin
      for (int i = 0; i < NDIG; i++) begin
        if (bcd[4*i +: 4] >= 4'd5) begin
          bcd[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
        end
      end
      bcd = {bcd[DIG_W-2:0], m[MW-1]};
      m   = {m[MW-2:0], 1'b0};
    end
    dd_digits = bcd;
    dd_mag    = m;
  end

  // highest nonzero digit, zero if none
  always_comb begin
    lead = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (digits_r[4*i +: 4] != 4'd0) begin
        lead = PTR_W'(i);
      end
    end
  end

  assign cur_digit = digits_r[4*ptr_r +: 4];
  assign out_load  = (state_r == S_EMIT) && (!out_valid_r || !out_stall);
  assign q_pop     = (state_r == S_IDLE) && q_valid;

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    digits_nxt    = digits_r;
    cnt_nxt       = cnt_r;
    ptr_nxt       = ptr_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          kind_nxt = q_ctl.kind;
          neg_nxt  = q_ctl.neg;
          mag_nxt  = mag_pad;
          unique case (q_ctl.kind)
            i2a_pkg::KIND_DEC: begin
              digits_nxt = '0;
              cnt_nxt    = CNT_W'(CONV_CYCLES);
              state_nxt  = S_CONV;
            end
            i2a_pkg::KIND_OCT: begin
              digits_nxt = oct_digits;
              state_nxt  = S_SCAN;
            end
            i2a_pkg::KIND_HEXL, i2a_pkg::KIND_HEXU: begin
              digits_nxt = DIG_W'(mag_pad);
              state_nxt  = S_SCAN;
            end
            default: state_nxt = S_EMIT;
          endcase
        end
      end
      S_CONV: begin
        digits_nxt = dd_digits;
        mag_nxt    = dd_mag;
        cnt_nxt    = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        ptr_nxt   = lead;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          if (kind_r == i2a_pkg::KIND_LIT) begin
            out_char_nxt = mag_r[i2a_pkg::CHAR_W-1:0];
            out_last_nxt = 1'b1;
            state_nxt    = S_IDLE;
          end else if (neg_r) begin
            out_char_nxt = i2a_pkg::CH_MINUS;
            out_last_nxt = 1'b0;
            neg_nxt      = 1'b0;
          end else begin
            out_char_nxt = i2a_pkg::digit_char(cur_digit, kind_r == i2a_pkg::KIND_HEXU);
            out_last_nxt = (ptr_r == '0);
            ptr_nxt      = ptr_r - PTR_W'(1);
            if (ptr_r == '0) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r     <= kind_nxt;
    neg_r      <= neg_nxt;
    mag_r      <= mag_nxt;
    digits_r   <= digits_nxt;
    cnt_r      <= cnt_nxt;
    ptr_r      <= ptr_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

  `I2A_ASSERT(a_conv_only_decimal, (state_r != S_CONV) || (kind_r == i2a_pkg::KIND_DEC))
  `I2A_ASSERT_NEXT(a_last_ends_run, out_load && out_last_nxt, state_r == S_IDLE)
  `I2A_ASSERT_NEXT(a_out_held, out_valid_r && out_stall, out_valid_r && $stable(out_char_r) && $stable(out_last_r))

endmodule

// File: sv/integer_to_ascii_formatter.sv
// An accepted word is written to the queue; the back end pops it in S_IDLE and then
// runs S_CONV and S_SCAN (decimal), S_SCAN (octal, hex) or neither (literal) before
// S_EMIT loads the first character into the output register. The back end holds
// one item at a time and takes the next only once its last character is loaded.
// A two-entry queue takes new words while the back end converts or stalls.
// Reset (synchronous, rst_n low) empties the queue and the output register.
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Converts an integer to ASCII in signed or unsigned decimal, octal or hex,
// or passes a literal character, one character per output word.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter #(
  parameter int VALUE_WIDTH = i2a_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [i2a_pkg::OPCODE_W-1:0]        in_opcode,
  input  logic [i2a_pkg::VALUE_FIELD_W-1:0]   in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [i2a_pkg::CHAR_W-1:0]          out_character,
  output logic                                out_last
);

  localparam int DATA_W = i2a_pkg::CTL_W + VALUE_WIDTH;

  logic                   push;
  i2a_pkg::ctl_t          push_ctl;
  logic [VALUE_WIDTH-1:0] push_mag;
  logic                   q_full;
  logic                   q_valid;
  logic                   q_pop;
  logic [DATA_W-1:0]      q_data;
  i2a_pkg::ctl_t          q_ctl;
  logic [VALUE_WIDTH-1:0] q_mag;

  i2a_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_opcode (in_opcode),
    .in_value  (in_value),
    .q_full    (q_full),
    .push      (push),
    .push_ctl  (push_ctl),
    .push_mag  (push_mag)
  );

  i2a_queue #(
    .DATA_W (DATA_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_ctl, push_mag}),
    .pop       (q_pop),
    .pop_data  (q_data),
    .not_empty (q_valid),
    .full      (q_full)
  );

  assign q_ctl = i2a_pkg::ctl_t'(q_data[DATA_W-1 -: i2a_pkg::CTL_W]);
  assign q_mag = q_data[VALUE_WIDTH-1:0];

  i2a_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_ctl         (q_ctl),
    .q_mag         (q_mag),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule
